>>> sv/morris_lecar_derivatives_assert.svh
// Assertion helpers for the derivative pipeline. In synthesis builds the
// macros expand to nothing.
`ifndef MORRIS_LECAR_DERIVATIVES_ASSERT_SVH
`define MORRIS_LECAR_DERIVATIVES_ASSERT_SVH
`ifndef SYNTH
`define MLD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MLD_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MLD_ASSERT(lbl, clk, rst, prop, msg)
`define MLD_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

>>> sv/mld_pkg.sv
`timescale 1ns / 1ps
package mld_pkg;

  typedef longint unsigned u64_t;

  localparam int LUT_ENTRIES = 256;
  localparam int STAGES      = 8;
  localparam int TAB_W       = 21;

  localparam u64_t ONE_Q30   = u64_t'(1) << 30;
  localparam int   ONE_Q16   = 65536;
  localparam int   HALF_Q16  = 32768;

  localparam int G_CA_Q16    = 72090;
  localparam int E_L_Q8      = -12800;
  localparam int E_CA_Q8     = 25600;
  localparam int E_K_Q8      = -17920;
  localparam int V_OFFSET_Q8 = 256;

  localparam int VR_MAX      = 524287;
  localparam int VR_MIN      = -524288;
  localparam int RR_MAX      = 131071;
  localparam int RR_MIN      = -131072;

  // Table positions are |x| * scale / 15; |x| never exceeds this count.
  localparam int POS_DIV       = 15;
  localparam int MAG_MAX       = 33023;
  localparam int RECIP15       = 34953;
  localparam int RECIP15_SHIFT = 19;

  // The recovery rate divides by 5 * 2^16: a shift, then a reciprocal of 5.
  localparam int DW_BIAS      = 163840;
  localparam int RECIP5       = 1677722;
  localparam int RECIP5_SHIFT = 23;

  typedef enum logic {
    TABLE_TANH,
    TABLE_COSH
  } table_kind_t;

  typedef struct packed {
    logic load_a;
    logic load_b;
  } stage_en_t;

  // exp(-t) in Q30 with u = t/256 in Q30: a nine term series, then
  // squared eight times.
  function automatic u64_t exp_neg_q30(u64_t u);
    u64_t term;
    u64_t sum;
    int   i;
    term = ONE_Q30;
    sum  = ONE_Q30;
    term = (term * u) >> 30;
    sum  = sum - term;
    term = ((term * u) >> 30) / 2;
    sum  = sum + term;
    term = ((term * u) >> 30) / 3;
    sum  = sum - term;
    term = ((term * u) >> 30) / 4;
    sum  = sum + term;
    term = ((term * u) >> 30) / 5;
    sum  = sum - term;
    term = ((term * u) >> 30) / 6;
    sum  = sum + term;
    term = ((term * u) >> 30) / 7;
    sum  = sum - term;
    term = ((term * u) >> 30) / 8;
    sum  = sum + term;
    for (i = 0; i < 8; i++) begin
      sum = (sum * sum + (ONE_Q30 >> 1)) >> 30;
    end
    return sum;
  endfunction

endpackage

>>> sv/mld_state_if.sv
`timescale 1ns / 1ps
interface mld_state_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] membrane_voltage;
  logic        [15:0] recovery_fraction;
  logic signed [15:0] input_current;

  modport source (
    output valid, membrane_voltage, recovery_fraction, input_current,
    input  ready
  );
  modport sink (
    input  valid, membrane_voltage, recovery_fraction, input_current,
    output ready
  );
endinterface

>>> sv/mld_rate_if.sv
`timescale 1ns / 1ps
interface mld_rate_if;
  logic               valid;
  logic               ready;
  logic signed [19:0] voltage_rate;
  logic signed [17:0] recovery_rate;
  logic               saturated;

  modport source (
    output valid, voltage_rate, recovery_rate, saturated,
    input  ready
  );
  modport sink (
    input  valid, voltage_rate, recovery_rate, saturated,
    output ready
  );
endinterface

>>> sv/morris_lecar_derivatives.sv
`timescale 1ns / 1ps
// Morris-Lecar derivative unit: for each transfer of membrane voltage
// (Q7.8 mV), recovery fraction (Q0.16) and injected current (Q7.8) it
// returns dV/dt in Q11.8 and dw/dt in Q1.16, each clipped to its field with
// the saturated flag raised on a clip. The unit is an eight-stage pipeline
// that takes one state per clock while not stalled and delivers its rates
// from its last stage; stages advance independently, so bubbles close up
// under output back-pressure and input is refused only when every stage is
// full. tanh and cosh come from constant tables of LutEntries + 1 points,
// generated at elaboration, interpolated linearly between neighbors.
`include "morris_lecar_derivatives_assert.svh"
module morris_lecar_derivatives #(
  parameter int LutEntries = mld_pkg::LUT_ENTRIES
) (
  input logic        clk,
  input logic        rst,
  mld_state_if.sink  state,
  mld_rate_if.source rates
);

  localparam int Stages = mld_pkg::STAGES;
  localparam int AddrW  = $clog2(LutEntries + 1);
  localparam int TabW   = mld_pkg::TAB_W;
  localparam int SumW   = 54;
  localparam int VrW    = SumW - 32;
  localparam int QW     = 43 - mld_pkg::RECIP5_SHIFT;

  // Stage i may load when it is empty or its item moves on this cycle.
  logic [Stages-1:0] valid;
  logic [Stages-1:0] valid_in;
  logic [Stages:0]   adv;

  always_comb begin
    adv[Stages] = rates.ready;
    for (int i = Stages - 1; i >= 0; i--) begin
      adv[i] = !valid[i] || adv[i+1];
    end
    valid_in = {valid[Stages-2:0], state.valid};
  end

  assign state.ready = adv[0];
  assign rates.valid = valid[Stages-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      for (int i = 0; i < Stages; i++) begin
        if (adv[i]) begin
          valid[i] <= valid_in[i];
        end
      end
    end
  end

  // Stages 0 to 3: positions, table reads and interpolation.
  mld_pkg::stage_en_t pos_en;
  mld_pkg::stage_en_t lut_en;
  assign pos_en = '{load_a: adv[0], load_b: adv[1]};
  assign lut_en = '{load_a: adv[2], load_b: adv[3]};

  logic signed [16:0] arg_m;
  logic signed [16:0] arg_w;
  assign arg_m = 17'(state.membrane_voltage) + 17'(mld_pkg::V_OFFSET_Q8);
  assign arg_w = 17'(state.membrane_voltage);

  logic [AddrW-1:0] addr_m, addr_w;
  logic [15:0]      frac_m, frac_w;
  logic             last_m, last_w, neg_m, neg_w;

  mld_position #(
    .LutEntries(LutEntries),
    .Scale     (32 * LutEntries)
  ) u_pos_m (
    .clk (clk),
    .en  (pos_en),
    .arg (arg_m),
    .addr(addr_m),
    .frac(frac_m),
    .last(last_m),
    .neg (neg_m)
  );

  mld_position #(
    .LutEntries(LutEntries),
    .Scale     (16 * LutEntries)
  ) u_pos_w (
    .clk (clk),
    .en  (pos_en),
    .arg (arg_w),
    .addr(addr_w),
    .frac(frac_w),
    .last(last_w),
    .neg (neg_w)
  );

  logic [TabW-1:0] tm3, tw3, cz3;

  mld_lut #(
    .LutEntries(LutEntries),
    .Kind      (mld_pkg::TABLE_TANH)
  ) u_tanh_m (
    .clk  (clk),
    .en   (lut_en),
    .addr (addr_m),
    .frac (frac_m),
    .last (last_m),
    .value(tm3)
  );

  mld_lut #(
    .LutEntries(LutEntries),
    .Kind      (mld_pkg::TABLE_TANH)
  ) u_tanh_w (
    .clk  (clk),
    .en   (lut_en),
    .addr (addr_w),
    .frac (frac_w),
    .last (last_w),
    .value(tw3)
  );

  mld_lut #(
    .LutEntries(LutEntries),
    .Kind      (mld_pkg::TABLE_COSH)
  ) u_cosh (
    .clk  (clk),
    .en   (lut_en),
    .addr (addr_w),
    .frac (frac_w),
    .last (last_w),
    .value(cz3)
  );

  logic signed [15:0] v0, v1, v2, v3, v4, v5;
  logic        [15:0] w0, w1, w2, w3;
  logic signed [15:0] c0, c1, c2, c3, c4, c5;
  logic               negm2, negw2, negm3, negw3;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      v0 <= state.membrane_voltage;
      w0 <= state.recovery_fraction;
      c0 <= state.input_current;
    end
    if (adv[1]) begin
      v1 <= v0;
      w1 <= w0;
      c1 <= c0;
    end
    if (adv[2]) begin
      v2    <= v1;
      w2    <= w1;
      c2    <= c1;
      negm2 <= neg_m;
      negw2 <= neg_w;
    end
    if (adv[3]) begin
      v3    <= v2;
      w3    <= w2;
      c3    <= c2;
      negm3 <= negm2;
      negw3 <= negw2;
    end
  end

  // Stage 4: sigmoids from the signed tanh values, winf - w and w * (V - E_K).
  logic signed [17:0] tanh_m, tanh_w, minf_sum, winf_sum, diff;
  logic        [16:0] minf_c, winf_c, dabs_c;
  logic signed [16:0] vk_c;

  always_comb begin
    tanh_m = signed'({1'b0, tm3[16:0]});
    if (negm3) begin
      tanh_m = -tanh_m;
    end
    tanh_w = signed'({1'b0, tw3[16:0]});
    if (negw3) begin
      tanh_w = -tanh_w;
    end
    minf_sum = 18'(mld_pkg::ONE_Q16) + tanh_m;
    winf_sum = 18'(mld_pkg::ONE_Q16) + tanh_w;
    minf_c   = minf_sum[17:1];
    winf_c   = winf_sum[17:1];
    diff     = signed'({1'b0, winf_c}) - signed'({2'b00, w3});
    dabs_c   = diff[17] ? 17'(-diff) : 17'(diff);
    vk_c     = 17'(v3) - 17'(mld_pkg::E_K_Q8);
  end

  logic        [16:0] minf4, dabs4;
  logic               dneg4, dneg5, dneg6;
  logic   [TabW-1:0]  cz4;
  logic signed [33:0] wt4, wt5;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      minf4 <= minf_c;
      dabs4 <= dabs_c;
      dneg4 <= diff[17];
      cz4   <= cz3;
      wt4   <= 34'(signed'({1'b0, w3})) * 34'(vk_c);
      v4    <= v3;
      c4    <= c3;
    end
  end

  // Stage 5: calcium conductance and the unscaled recovery product.
  logic [32:0] gm5;
  logic [37:0] dp5;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      gm5   <= 33'(minf4) * 33'(mld_pkg::G_CA_Q16);
      dp5   <= 38'(dabs4) * 38'(cz4);
      dneg5 <= dneg4;
      wt5   <= wt4;
      v5    <= v4;
      c5    <= c4;
    end
  end

  // Stage 6: calcium current, the linear terms of dV/dt in Q40 with the
  // rounding half already added, and the divide by five.
  logic signed [16:0] vl_c, vca_c;
  logic        [37:0] dw_round;

  always_comb begin
    vl_c     = 17'(v5) - 17'(mld_pkg::E_L_Q8);
    vca_c    = 17'(v5) - 17'(mld_pkg::E_CA_Q8);
    dw_round = dp5 + 38'(mld_pkg::DW_BIAS);
  end

  logic signed [SumW-1:0] ca6, lin6;
  logic        [42:0]     ym6;

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      ca6   <= SumW'(signed'({1'b0, gm5})) * SumW'(vca_c);
      lin6  <= (SumW'(c5) <<< 32) - (SumW'(vl_c) <<< 31) - (SumW'(wt5) <<< 17) +
               (SumW'(1) <<< 31);
      ym6   <= 43'(dw_round[37:16]) * 43'(mld_pkg::RECIP5);
      dneg6 <= dneg5;
    end
  end

  // Stage 7: final sum, signs and clipping into the output register.
  logic signed [SumW-1:0] s_c;
  logic signed [VrW-1:0]  vr_full;
  logic        [QW-1:0]   q_c;
  logic signed [QW:0]     rr_full;
  logic                   vr_hi, vr_lo, rr_hi, rr_lo;

  always_comb begin
    s_c     = lin6 - ca6;
    vr_full = s_c[SumW-1:32];
    q_c     = ym6[42:mld_pkg::RECIP5_SHIFT];
    rr_full = dneg6 ? -signed'({1'b0, q_c}) : signed'({1'b0, q_c});
    vr_hi   = vr_full > VrW'(mld_pkg::VR_MAX);
    vr_lo   = vr_full < VrW'(mld_pkg::VR_MIN);
    rr_hi   = rr_full > (QW+1)'(mld_pkg::RR_MAX);
    rr_lo   = rr_full < (QW+1)'(mld_pkg::RR_MIN);
  end

  logic signed [19:0] vr_out;
  logic signed [17:0] rr_out;
  logic               sat_out;

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      if (vr_hi) begin
        vr_out <= 20'(mld_pkg::VR_MAX);
      end else if (vr_lo) begin
        vr_out <= 20'(mld_pkg::VR_MIN);
      end else begin
        vr_out <= 20'(vr_full);
      end
      if (rr_hi) begin
        rr_out <= 18'(mld_pkg::RR_MAX);
      end else if (rr_lo) begin
        rr_out <= 18'(mld_pkg::RR_MIN);
      end else begin
        rr_out <= 18'(rr_full);
      end
      sat_out <= vr_hi || vr_lo || rr_hi || rr_lo;
    end
  end

  assign rates.voltage_rate  = vr_out;
  assign rates.recovery_rate = rr_out;
  assign rates.saturated     = sat_out;

  `MLD_ASSERT_NR(a_reset_flush, clk, rst |=> !rates.valid, "output valid right after reset")
  `MLD_ASSERT(a_full_when_stalled, clk, rst, !state.ready |-> &valid, "input refused with a bubble in the pipeline")
  `MLD_ASSERT(a_entry_lands, clk, rst, state.valid && state.ready |=> valid[0], "accepted transfer did not reach the first stage")
  `MLD_ASSERT(a_entry_holds, clk, rst, valid[0] && !adv[1] |=> valid[0], "stalled first stage lost its item")
  `MLD_ASSERT(a_sat_flag, clk, rst, rates.valid && rates.voltage_rate != 20'(mld_pkg::VR_MAX) && rates.voltage_rate != 20'(mld_pkg::VR_MIN) && rates.recovery_rate != 18'(mld_pkg::RR_MAX) && rates.recovery_rate != 18'(mld_pkg::RR_MIN) |-> !rates.saturated, "saturated flag without a clipped rate")

endmodule

>>> sv/mld_position.sv
`timescale 1ns / 1ps
// Two stages: |arg| / 15 through a reciprocal, then the table position
// |arg| * Scale / 15 split into a table address and a 16-bit fraction.
module mld_position #(
  parameter int LutEntries = mld_pkg::LUT_ENTRIES,
  parameter int Scale      = 16 * mld_pkg::LUT_ENTRIES,
  localparam int AddrW = $clog2(LutEntries + 1),
  localparam int PosW  = $clog2((mld_pkg::u64_t'(mld_pkg::MAG_MAX) *
                                 mld_pkg::u64_t'(Scale)) / mld_pkg::POS_DIV + 1),
  localparam int IdxW  = PosW - 16
) (
  input  logic                clk,
  input  mld_pkg::stage_en_t  en,
  input  logic signed [16:0]  arg,
  output logic [AddrW-1:0]    addr,
  output logic [15:0]         frac,
  output logic                last,
  output logic                neg
);

  logic [PosW-1:0] frac_tab [16];

  // Fractional part of a remainder times the scale, built at elaboration.
  for (genvar r = 0; r < 16; r++) begin : g_frac
    localparam mld_pkg::u64_t FracV =
      (mld_pkg::u64_t'(r) * mld_pkg::u64_t'(Scale)) / mld_pkg::POS_DIV;
    assign frac_tab[r] = PosW'(FracV);
  end

  logic [15:0] mag_c;
  logic [15:0] mag_a;
  logic        neg_a;
  logic [31:0] qprod_a;

  always_comb begin
    mag_c = arg[16] ? 16'(-arg) : 16'(arg);
  end

  always_ff @(posedge clk) begin
    if (en.load_a) begin
      mag_a   <= mag_c;
      neg_a   <= arg[16];
      qprod_a <= 32'(mag_c) * 32'(mld_pkg::RECIP15);
    end
  end

  logic [31-mld_pkg::RECIP15_SHIFT:0] quot;
  logic [15:0]                        rem16;
  logic [PosW-1:0]                    pos;
  logic [IdxW-1:0]                    idx;
  logic                               last_c;

  always_comb begin
    quot   = qprod_a[31:mld_pkg::RECIP15_SHIFT];
    rem16  = mag_a - 16'(32'(quot) * 32'(mld_pkg::POS_DIV));
    pos    = PosW'(quot) * PosW'(Scale) + frac_tab[rem16[3:0]];
    idx    = pos[PosW-1:16];
    last_c = longint'(idx) >= longint'(LutEntries);
  end

  always_ff @(posedge clk) begin
    if (en.load_b) begin
      addr <= last_c ? AddrW'(LutEntries - 1) : AddrW'(idx);
      frac <= pos[15:0];
      last <= last_c;
      neg  <= neg_a;
    end
  end

endmodule

>>> sv/mld_lut.sv
`timescale 1ns / 1ps
// Constant table of tanh(8k/N) or cosh(4k/N) in Q16, read at two
// neighboring entries and linearly interpolated over two stages.
module mld_lut #(
  parameter int                   LutEntries = mld_pkg::LUT_ENTRIES,
  parameter mld_pkg::table_kind_t Kind       = mld_pkg::TABLE_TANH,
  localparam int AddrW = $clog2(LutEntries + 1),
  localparam int TabW  = mld_pkg::TAB_W
) (
  input  logic               clk,
  input  mld_pkg::stage_en_t en,
  input  logic [AddrW-1:0]   addr,
  input  logic [15:0]        frac,
  input  logic               last,
  output logic [TabW-1:0]    value
);

  localparam mld_pkg::u64_t One = mld_pkg::ONE_Q30;

  logic [TabW-1:0] rom [LutEntries+1];

  for (genvar k = 0; k <= LutEntries; k++) begin : g_rom
    localparam mld_pkg::u64_t U =
      (mld_pkg::u64_t'(k) << ((Kind == mld_pkg::TABLE_TANH) ? 26 : 24)) /
      mld_pkg::u64_t'(LutEntries);
    localparam mld_pkg::u64_t E0 = mld_pkg::exp_neg_q30(U);
    localparam mld_pkg::u64_t ET = (E0 > One) ? One : E0;
    localparam mld_pkg::u64_t EC = (E0 == 0) ? mld_pkg::u64_t'(1) : E0;
    localparam mld_pkg::u64_t TanhV =
      (((One - ET) << 16) + ((One + ET) >> 1)) / (One + ET);
    localparam mld_pkg::u64_t CoshV =
      ((One * One) / EC + EC + (mld_pkg::u64_t'(1) << 14)) >> 15;
    assign rom[k] = (Kind == mld_pkg::TABLE_TANH) ? TabW'(TanhV) : TabW'(CoshV);
  end

  logic [TabW-1:0] lo;
  logic [TabW-1:0] hi;
  logic [15:0]     frac_r;
  logic            last_r;

  always_ff @(posedge clk) begin
    if (en.load_a) begin
      lo     <= rom[addr];
      hi     <= rom[addr + AddrW'(1)];
      frac_r <= frac;
      last_r <= last;
    end
  end

  logic signed [TabW:0]    dlt;
  logic signed [TabW+17:0] mix;
  logic signed [TabW+17:0] interp;

  // lo*(1-f) + hi*f rounded equals lo + round((hi-lo)*f) with a floor shift.
  always_comb begin
    dlt    = signed'({1'b0, hi}) - signed'({1'b0, lo});
    mix    = (TabW+18)'(dlt) * (TabW+18)'(signed'({1'b0, frac_r})) +
             (TabW+18)'(mld_pkg::HALF_Q16);
    interp = (TabW+18)'(signed'({1'b0, lo})) + (mix >>> 16);
  end

  always_ff @(posedge clk) begin
    if (en.load_b) begin
      value <= last_r ? hi : TabW'(interp);
    end
  end

endmodule
